@@ rtl/sabs_pkg.sv @@
// Shared types and constants for the sorted key store with binary search.
// No dependencies; imported by every module of the block.
package sabs_pkg;

    // Field widths of the stream items and the length register
    localparam int KEY_W        = 32;
    localparam int IDX_W        = 10;
    localparam int POS_W        = 10;
    localparam int LEN_W        = 11;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 16;
    localparam int DEF_STORE_DEPTH = 1024;

    // Item kinds carried on the input tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr_en;     // store the incoming key at its index
        logic start;     // load the search window and issue the first probe
        logic step;      // narrow the window and issue the next probe
        logic out_load;  // move the search outcome into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic done;      // current probe ends the search
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage

@@ rtl/sorted_array_binary_search_top.sv @@
// Top level of the sorted key store with binary search.
// Depends on sabs_pkg, sabs_ctrl and sabs_dpath.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+----------------------------------
//  s        | in        | i_s_tvalid/o_s_tready  | tuser: cmd; tdata: index, key
//  m        | out       | o_m_tvalid/i_m_tready  | tuser: found; tdata: position
//  cfg      | in        | i_cfg_valid/o_cfg_ready| data: array_length
//
// A write transaction leaves the input ready; the next item is taken in the next cycle.
// A search makes at most ceil(log2(len)) + 1 probes (11 at 1024 entries) after
// it is accepted: one read of the single memory read port each cycle, with the
// next address formed from the compare.
// Reset is synchronous and active low; it sets array_length to 1 and empties
// the output register. The key memory is not cleared. Neither input channel
// is ready while reset is held.
// A stalled output holds the finished search; the input stays not ready until
// the result moves into the output register.
module sorted_array_binary_search_top #(
    parameter int STORE_DEPTH = sabs_pkg::DEF_STORE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [sabs_pkg::S_TDATA_W-1:0]   i_s_tdata,  // [9:0] index, [41:10] key
    input  logic                             i_s_tuser,  // [0] cmd
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [sabs_pkg::M_TDATA_W-1:0]   o_m_tdata,  // [9:0] position
    output logic                             o_m_tuser,  // [0] found
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sabs_pkg::LEN_W-1:0]       i_cfg_data
);
    import sabs_pkg::*;

    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    logic [IDX_W-1:0]  s_index;
    logic [KEY_W-1:0]  s_key;
    logic [POS_W-1:0]  m_position;

    // Unpack the input item
    assign s_index = i_s_tdata[IDX_W-1:0];
    assign s_key   = i_s_tdata[IDX_W+KEY_W-1:IDX_W];

    // Take configuration writes at once, outside reset
    assign o_cfg_ready = i_rst_n;

    sabs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_cmd    (i_s_tuser),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_s_tready (o_s_tready)
    );

    sabs_dpath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_cfg_wr     (i_cfg_valid),
        .i_cfg_len    (i_cfg_data),
        .i_index      (s_index),
        .i_key        (s_key),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_found    (o_m_tuser),
        .o_m_position (m_position)
    );

    // Pack the result item, zero filled to whole bytes
    assign o_m_tdata = {{(M_TDATA_W-POS_W){1'b0}}, m_position};

endmodule

@@ rtl/sabs_ctrl.sv @@
// Controller state machine of the binary search block.
// Depends on sabs_pkg for the command and status structs.
module sabs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_cmd,
    input  sabs_pkg::t_dp_stat i_stat,
    output sabs_pkg::t_dp_cmd  o_cmd,
    output logic               o_s_tready
);
    import sabs_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state r_state;
    logic   r_s_tready;
    logic   s_accept;

    assign s_accept   = i_s_tvalid && r_s_tready;
    assign o_s_tready = r_s_tready;

    // Decode commands from state and status
    always_comb begin
        o_cmd          = '0;
        o_cmd.wr_en    = s_accept && (i_s_cmd == CMD_WRITE);
        o_cmd.start    = s_accept && (i_s_cmd == CMD_SEARCH);
        o_cmd.step     = (r_state == S_SEARCH) && !i_stat.done;
        o_cmd.out_load = (r_state == S_SEARCH) && i_stat.done && i_stat.out_free;
    end

    // Advance state; hold the input ready low in reset and while a search runs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s_tready <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept && (i_s_cmd == CMD_SEARCH)) begin
                        r_state    <= S_SEARCH;
                        r_s_tready <= 1'b0;
                    end else begin
                        r_s_tready <= 1'b1;
                    end
                end
                S_SEARCH: begin
                    if (i_stat.done && i_stat.out_free) begin
                        r_state    <= S_IDLE;
                        r_s_tready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_s_tready <= 1'b0;
                end
            endcase
        end
    end

endmodule

@@ rtl/sabs_dpath.sv @@
// Datapath of the binary search block: key memory, search window,
// length register and output register. Depends on sabs_pkg.
module sabs_dpath #(
    parameter int STORE_DEPTH = sabs_pkg::DEF_STORE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sabs_pkg::t_dp_cmd               i_cmd,
    output sabs_pkg::t_dp_stat              o_stat,
    input  logic                            i_cfg_wr,
    input  logic [sabs_pkg::LEN_W-1:0]      i_cfg_len,
    input  logic [sabs_pkg::IDX_W-1:0]      i_index,
    input  logic [sabs_pkg::KEY_W-1:0]      i_key,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic                            o_m_found,
    output logic [sabs_pkg::POS_W-1:0]      o_m_position
);
    import sabs_pkg::*;

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int LW  = $clog2(STORE_DEPTH + 1);
    localparam int CW  = (LW > LEN_W) ? LW : LEN_W;
    localparam int IW  = ((AW + 1) > IDX_W) ? (AW + 1) : IDX_W;
    localparam int PW  = (AW > POS_W) ? AW : POS_W;

    logic        [KEY_W-1:0] mem [STORE_DEPTH];
    logic signed [KEY_W-1:0] r_rd_data;
    logic signed [KEY_W-1:0] r_key;
    logic        [LEN_W-1:0] r_cfg_len;
    logic        [AW-1:0]    r_base;
    logic        [LW-1:0]    r_len;
    logic                    r_m_tvalid;
    logic                    r_m_found;
    logic        [POS_W-1:0] r_m_position;

    logic        [CW-1:0]    cfg_ext;
    logic        [LW-1:0]    sat_len;
    logic        [AW-1:0]    probe;
    logic        [PW-1:0]    probe_ext;
    logic                    hit;
    logic                    key_gt;
    logic        [AW-1:0]    n_base;
    logic        [LW-1:0]    n_len;
    logic        [AW-1:0]    rd_addr;
    logic                    wr_ok;

    // Saturate the configured length to the store depth
    assign cfg_ext = CW'(r_cfg_len);
    assign sat_len = (cfg_ext > CW'(STORE_DEPTH)) ? LW'(STORE_DEPTH) : LW'(cfg_ext);

    // Compare the probed entry with the key
    assign probe     = r_base + AW'(r_len >> 1);
    assign probe_ext = PW'(probe);
    assign hit       = (r_rd_data == r_key) && (r_len != '0);
    assign key_gt    = r_key > r_rd_data;

    // Narrow the window toward the key
    always_comb begin
        if (key_gt) begin
            n_base = probe;
            n_len  = r_len - (r_len >> 1);
        end else begin
            n_base = r_base;
            n_len  = r_len >> 1;
        end
    end

    // Select the read address: first probe, next probe, or hold the current one
    always_comb begin
        if (i_cmd.start) begin
            rd_addr = AW'(sat_len >> 1);
        end else if (i_cmd.step) begin
            rd_addr = n_base + AW'(n_len >> 1);
        end else begin
            rd_addr = probe;
        end
    end

    assign wr_ok = i_cmd.wr_en && (IW'(i_index) < IW'(STORE_DEPTH));

    // Key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[AW'(i_index)] <= i_key;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Hold the length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= LEN_W'(1);
        end else if (i_cfg_wr) begin
            r_cfg_len <= i_cfg_len;
        end
    end

    // Load or narrow the search window
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key  <= i_key;
            r_base <= '0;
            r_len  <= sat_len;
        end else if (i_cmd.step) begin
            r_base <= n_base;
            r_len  <= n_len;
        end
    end

    // Output register: valid flag under reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_found    <= hit;
            r_m_position <= hit ? probe_ext[POS_W-1:0] : '0;
        end
    end

    assign o_stat.done     = hit || (r_len <= LW'(1));
    assign o_stat.out_free = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid      = r_m_tvalid;
    assign o_m_found       = r_m_found;
    assign o_m_position    = r_m_position;

endmodule

@@ rtl/sabs_checker.sv @@
// Port-level checks of the binary search block, bound to the top level.
// Depends on sabs_pkg for field widths and item kinds.
module sabs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [sabs_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input logic                             o_m_tuser
);
    import sabs_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed or dropped");

    // A write transaction leaves the block ready for the next item
    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == CMD_WRITE) |=> o_s_tready)
        else $error("input not ready after a write");

    // A search transaction drops the input ready once it is accepted
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == CMD_SEARCH) |=> !o_s_tready)
        else $error("input ready during a search");

    // A miss reports position zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata == '0))
        else $error("miss with nonzero position");

endmodule

bind sorted_array_binary_search_top sabs_checker u_sabs_checker (.*);
